>>> rtl/afsm_pkg.sv
// shared types, constants and the character fold table for the accent folding matcher
package afsm_pkg;

    typedef enum logic [1:0] {
        OP_PAT_BYTE = 2'd0,
        OP_PAT_END  = 2'd1,
        OP_TXT_BYTE = 2'd2,
        OP_TXT_END  = 2'd3
    } op_t;

    localparam logic [7:0] LEAD_MASK  = 8'hFE;
    localparam logic [7:0] LEAD_C2    = 8'hC2;
    localparam logic [7:0] LOW6_MASK  = 8'h3F;
    localparam logic [7:0] LEAD_BIT0  = 8'h40;
    localparam logic [7:0] HIGH_BIT   = 8'h80;
    localparam logic [7:0] ASCII_LC_A = 8'h61;
    localparam logic [7:0] ASCII_LC_Z = 8'h7A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    // latin-1 code points 0x80..0xff with accents stripped and upper-cased
    localparam logic [7:0] LATIN_FOLD [0:127] = '{
        8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
        8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F,
        8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97,
        8'h98, 8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9D, 8'h9E, 8'h9F,
        8'hA0, 8'hA1, 8'h43, 8'hA3, 8'hA4, 8'hA5, 8'hA6, 8'hA7,
        8'hA8, 8'hA9, 8'h41, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF,
        8'hB0, 8'hB1, 8'h32, 8'h33, 8'hB4, 8'h55, 8'hB6, 8'hB7,
        8'hB8, 8'h31, 8'h4F, 8'hBB, 8'hBC, 8'hBD, 8'hBE, 8'hBF,
        8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h43,
        8'h45, 8'h45, 8'h45, 8'h45, 8'h49, 8'h49, 8'h49, 8'h49,
        8'h44, 8'h4E, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'hD7,
        8'h4F, 8'h55, 8'h55, 8'h55, 8'h55, 8'h59, 8'hDE, 8'h53,
        8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h43,
        8'h45, 8'h45, 8'h45, 8'h45, 8'h49, 8'h49, 8'h49, 8'h49,
        8'h44, 8'h4E, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'hF7,
        8'h4F, 8'h55, 8'h55, 8'h55, 8'h55, 8'h59, 8'hFE, 8'h59
    };

    // what one request does to the pattern and text sides
    typedef struct packed {
        logic       new_pat;
        logic       pat_emit;
        logic [7:0] pat_ch;
        logic       txt_emit;
        logic [7:0] txt_ch;
        logic       end_text;
    } ctl_t;

    // 256-entry fold rom: ascii upper-cased, upper half through the latin table
    function automatic logic [7:0] fold_char(input logic [7:0] idx);
        logic [7:0] r;
        if (idx[7])
        begin
            r = LATIN_FOLD[idx[6:0]];
        end
        else if (idx >= ASCII_LC_A && idx <= ASCII_LC_Z)
        begin
            r = idx - CASE_DELTA;
        end
        else
        begin
            r = idx;
        end
        return r;
    endfunction

endpackage

>>> rtl/afsm_fold.sv
// utf-8 front end: lead byte tracking, pattern open/close and character folding
module afsm_fold (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  afsm_pkg::op_t    op,
    input  logic [7:0]       data_byte,
    output afsm_pkg::ctl_t   ctl
);

    logic [1:0] lead_reg;
    logic [1:0] lead_next;
    logic       closed_reg;
    logic       closed_next;

    logic       new_pat;
    logic [1:0] lead_eff;
    logic [1:0] lead_t;
    logic [1:0] feed_lead;
    logic [7:0] idx;
    logic       is_lead_byte;
    logic [7:0] feed_ch;
    logic       feed_emit;
    logic [1:0] feed_lead_next;
    logic [7:0] flush_p;
    logic [7:0] flush_t;

    always_comb
    begin
        new_pat  = (op == afsm_pkg::OP_PAT_BYTE || op == afsm_pkg::OP_PAT_END) && closed_reg;
        lead_eff = new_pat ? 2'b00 : lead_reg;
        // an open pattern takes the held lead byte before any text is seen
        lead_t    = closed_reg ? lead_reg : 2'b00;
        feed_lead = (op == afsm_pkg::OP_PAT_BYTE) ? lead_eff : lead_t;

        is_lead_byte = (data_byte & afsm_pkg::LEAD_MASK) == afsm_pkg::LEAD_C2;
        if (feed_lead[1])
        begin
            idx = afsm_pkg::HIGH_BIT | (feed_lead[0] ? afsm_pkg::LEAD_BIT0 : 8'h00)
                | (data_byte & afsm_pkg::LOW6_MASK);
        end
        else
        begin
            idx = data_byte;
        end
        feed_ch        = (feed_lead[1] || !data_byte[7]) ? afsm_pkg::fold_char(idx) : data_byte;
        feed_emit      = feed_lead[1] || !is_lead_byte;
        feed_lead_next = (!feed_lead[1] && is_lead_byte) ? {1'b1, data_byte[0]} : 2'b00;

        flush_p = afsm_pkg::LEAD_C2 | {7'b0, lead_eff[0]};
        flush_t = afsm_pkg::LEAD_C2 | {7'b0, lead_t[0]};

        ctl          = '0;
        ctl.new_pat  = new_pat;
        lead_next    = 2'b00;
        closed_next  = 1'b1;
        case (op)
            afsm_pkg::OP_PAT_BYTE:
            begin
                ctl.pat_emit = feed_emit;
                ctl.pat_ch   = feed_ch;
                lead_next    = feed_lead_next;
                closed_next  = 1'b0;
            end
            afsm_pkg::OP_PAT_END:
            begin
                ctl.pat_emit = lead_eff[1];
                ctl.pat_ch   = flush_p;
            end
            afsm_pkg::OP_TXT_BYTE:
            begin
                ctl.pat_emit = !closed_reg && lead_reg[1];
                ctl.pat_ch   = flush_p;
                ctl.txt_emit = feed_emit;
                ctl.txt_ch   = feed_ch;
                lead_next    = feed_lead_next;
            end
            afsm_pkg::OP_TXT_END:
            begin
                ctl.pat_emit = !closed_reg && lead_reg[1];
                ctl.pat_ch   = flush_p;
                ctl.txt_emit = lead_t[1];
                ctl.txt_ch   = flush_t;
                ctl.end_text = 1'b1;
            end
            default:
            begin
                closed_next = closed_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg   <= 2'b00;
            closed_reg <= 1'b1;
        end
        else if (advance)
        begin
            lead_reg   <= lead_next;
            closed_reg <= closed_next;
        end
    end

endmodule

>>> rtl/afsm_match.sv
// folded pattern store, text window and parallel window compare
module afsm_match #(
    parameter int unsigned MAX_PATTERN = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  afsm_pkg::ctl_t ctl,
    output logic           res_found,
    output logic           res_ovf
);

    localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

    // newest char sits at index MAX_PATTERN-1 in both shift lines
    logic [7:0]       pat_reg [MAX_PATTERN];
    logic [7:0]       pat_next [MAX_PATTERN];
    logic [7:0]       win_reg [MAX_PATTERN];
    logic [7:0]       win_next [MAX_PATTERN];
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] tcnt_reg;
    logic [LEN_W-1:0] tcnt_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             hit_reg;
    logic             hit_next;

    logic [LEN_W-1:0] len_b;
    logic [LEN_W-1:0] tcnt_b;
    logic             ovf_b;
    logic             hit_b;
    logic             pat_shift;
    logic             hit_now;
    logic [MAX_PATTERN-1:0] lane_ok;

    always_comb
    begin
        len_b  = ctl.new_pat ? '0 : len_reg;
        ovf_b  = ctl.new_pat ? 1'b0 : ovf_reg;
        tcnt_b = ctl.new_pat ? '0 : tcnt_reg;
        hit_b  = ctl.new_pat ? 1'b0 : hit_reg;

        // chars past capacity are dropped and flag the overflow
        pat_shift = ctl.pat_emit && (len_b != LEN_MAX);
        len_next  = len_b + LEN_W'(pat_shift);
        ovf_next  = ovf_b | (ctl.pat_emit && !pat_shift);
        tcnt_next = tcnt_b + LEN_W'(ctl.txt_emit && (tcnt_b != LEN_MAX));

        for (int k = 0; k < MAX_PATTERN - 1; k++)
        begin
            pat_next[k] = pat_shift ? pat_reg[k+1] : pat_reg[k];
            win_next[k] = ctl.txt_emit ? win_reg[k+1] : win_reg[k];
        end
        pat_next[MAX_PATTERN-1] = pat_shift ? ctl.pat_ch : pat_reg[MAX_PATTERN-1];
        win_next[MAX_PATTERN-1] = ctl.txt_emit ? ctl.txt_ch : win_reg[MAX_PATTERN-1];
    end

    // a lane counts only when it lies inside the last len_next chars
    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_lane
        assign lane_ok[k] = (pat_next[k] == win_next[k])
                          || !(len_next > LEN_W'(MAX_PATTERN - 1 - k));
    end

    always_comb
    begin
        hit_now   = ctl.txt_emit && (len_next != '0) && (tcnt_next >= len_next) && (&lane_ok);
        hit_next  = hit_b | hit_now;
        res_ovf   = ovf_next;
        res_found = !ovf_next && ((len_next == '0) || hit_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            tcnt_reg <= '0;
            ovf_reg  <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else if (advance)
        begin
            len_reg  <= len_next;
            ovf_reg  <= ovf_next;
            tcnt_reg <= ctl.end_text ? '0 : tcnt_next;
            hit_reg  <= ctl.end_text ? 1'b0 : hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pat_reg <= pat_next;
            win_reg <= win_next;
        end
    end

endmodule

>>> rtl/accent_folding_substring_match.sv
// Top level of the accent and case insensitive substring matcher.
// Input channel (in_valid/in_ready, opcode, data_byte) carries one request per
// byte: pattern bytes, end of pattern, text bytes, end of text. Bytes are
// folded as utf-8 (ascii upper-cased, 0xC2/0xC3 pairs folded as latin-1 with
// accents stripped). The folded pattern is held for any number of texts.
// Output channel (out_valid/out_ready, found, pattern_overflow) carries one
// result for each end-of-text request; other requests give none.
// Throughput is one request per cycle while no end-of-text request stalls:
// the input register feeds the fold table and the parallel compare of the
// text window against the pattern combinationally, then the result register.
// A request waits in the input register until it advances; an end-of-text
// request then loads the result register, which holds the result until it is taken.
// While a result waits, requests that give no result keep flowing; an
// end-of-text request stalls in the input register until the result is taken.
// Reset clears the handshake state and leaves an empty closed pattern, which
// matches any text.
module accent_folding_substring_match #(
    parameter int unsigned MAX_PATTERN = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] opcode,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       found,
    output logic       pattern_overflow
);

    logic           in_valid_reg;
    logic           in_valid_next;
    logic [1:0]     opcode_reg;
    logic [7:0]     byte_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           found_reg;
    logic           ovf_reg;

    afsm_pkg::op_t  op;
    afsm_pkg::ctl_t ctl;
    logic           is_end;
    logic           advance;
    logic           res_found;
    logic           res_ovf;

    assign op      = afsm_pkg::op_t'(opcode_reg);
    assign is_end  = (op == afsm_pkg::OP_TXT_END);
    assign advance = in_valid_reg && (!is_end || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        if (advance && is_end)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        end
    end

    afsm_fold u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .op        (op),
        .data_byte (byte_reg),
        .ctl       (ctl)
    );

    afsm_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .ctl       (ctl),
        .res_found (res_found),
        .res_ovf   (res_ovf)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            opcode_reg <= opcode;
            byte_reg   <= data_byte;
        end
        if (advance && is_end)
        begin
            found_reg <= res_found;
            ovf_reg   <= res_ovf;
        end
    end

    assign out_valid        = out_valid_reg;
    assign found            = found_reg;
    assign pattern_overflow = ovf_reg;

    // an overflowed pattern never reports a match
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pattern_overflow |-> !found)
        else $error("found set with pattern overflow");

    // the input side only stalls behind an unaccepted result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a waiting result");

    // a new result always comes from a request held in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid_reg))
        else $error("result without a request");

endmodule

>>> bench/accent_folding_substring_match_checker.sv
// checker for the accent folding matcher: watches both channels, predicts and compares results
module accent_folding_substring_match_checker #(
    parameter int unsigned MAX_PATTERN = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        found,
    input  logic        pattern_overflow,
    output int unsigned mismatches,
    output int unsigned answers_due,
    output int unsigned results_seen,
    output int unsigned hits_seen,
    output int unsigned overflows_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        found;
        logic        overflow;
        int unsigned tag;
    } answer_t;

    // latin-1 0x80..0xff: accents stripped, upper-cased
    localparam logic [7:0] ACCENT_FOLD [128] = '{
        8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
        8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F,
        8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97,
        8'h98, 8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9D, 8'h9E, 8'h9F,
        8'hA0, 8'hA1, 8'h43, 8'hA3, 8'hA4, 8'hA5, 8'hA6, 8'hA7,
        8'hA8, 8'hA9, 8'h41, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF,
        8'hB0, 8'hB1, 8'h32, 8'h33, 8'hB4, 8'h55, 8'hB6, 8'hB7,
        8'hB8, 8'h31, 8'h4F, 8'hBB, 8'hBC, 8'hBD, 8'hBE, 8'hBF,
        8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h43,
        8'h45, 8'h45, 8'h45, 8'h45, 8'h49, 8'h49, 8'h49, 8'h49,
        8'h44, 8'h4E, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'hD7,
        8'h4F, 8'h55, 8'h55, 8'h55, 8'h55, 8'h59, 8'hDE, 8'h53,
        8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h43,
        8'h45, 8'h45, 8'h45, 8'h45, 8'h49, 8'h49, 8'h49, 8'h49,
        8'h44, 8'h4E, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'hF7,
        8'h4F, 8'h55, 8'h55, 8'h55, 8'h55, 8'h59, 8'hFE, 8'h59
    };

    // bit 1: a lead byte is held, bit 0: its low bit
    logic [1:0]  lead_hold;
    logic [7:0]  pat_chars [MAX_PATTERN];
    int unsigned pat_len;
    bit          pat_done;
    logic [7:0]  text_win [MAX_PATTERN];
    int unsigned text_seen;
    bit          hit_seen;
    bit          pat_overflow;
    int unsigned answers_made;
    answer_t     match_answers [$];
    answer_t     head;

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic void clear_matcher();
        lead_hold    = '0;
        pat_len      = 0;
        pat_done     = 1'b1;
        text_seen    = 0;
        hit_seen     = 1'b0;
        pat_overflow = 1'b0;
    endfunction

    function automatic void store_char(bit to_text, logic [7:0] ch);
        bit same;
        if (!to_text)
        begin
            if (pat_len < MAX_PATTERN)
            begin
                pat_chars[pat_len] = ch;
                pat_len++;
            end
            else
            begin
                pat_overflow = 1'b1;
            end
        end
        else
        begin
            for (int i = 0; i < MAX_PATTERN - 1; i++)
                text_win[i] = text_win[i + 1];
            text_win[MAX_PATTERN - 1] = ch;
            if (text_seen < MAX_PATTERN)
                text_seen++;
            if (pat_len > 0 && text_seen >= pat_len)
            begin
                same = 1'b1;
                for (int i = 0; i < pat_len; i++)
                    if (pat_chars[i] !== text_win[MAX_PATTERN - pat_len + i])
                        same = 1'b0;
                if (same)
                    hit_seen = 1'b1;
            end
        end
    endfunction

    function automatic void fold_byte(bit to_text, logic [7:0] b);
        logic [7:0] ch;
        if (lead_hold[1])
        begin
            ch = ACCENT_FOLD[{lead_hold[0], b[5:0]}];
            lead_hold = '0;
            store_char(to_text, ch);
        end
        else if (!b[7])
        begin
            store_char(to_text, (b >= afsm_pkg::ASCII_LC_A && b <= afsm_pkg::ASCII_LC_Z)
                                ? b - afsm_pkg::CASE_DELTA : b);
        end
        else if ((b & afsm_pkg::LEAD_MASK) == afsm_pkg::LEAD_C2)
        begin
            lead_hold = {1'b1, b[0]};
        end
        else
        begin
            store_char(to_text, b);
        end
    endfunction

    // a lead byte at the end of a string goes through as it is
    function automatic void flush_lead(bit to_text);
        logic [7:0] ch;
        if (lead_hold[1])
        begin
            ch = afsm_pkg::LEAD_C2 | {7'd0, lead_hold[0]};
            lead_hold = '0;
            store_char(to_text, ch);
        end
    endfunction

    function automatic void start_pattern();
        pat_len      = 0;
        pat_overflow = 1'b0;
        pat_done     = 1'b0;
        lead_hold    = '0;
        text_seen    = 0;
        hit_seen     = 1'b0;
    endfunction

    function automatic void close_pattern();
        flush_lead(1'b0);
        pat_done = 1'b1;
    endfunction

    function automatic void fold_and_match(afsm_pkg::op_t op, logic [7:0] b);
        answer_t a;
        case (op)
            afsm_pkg::OP_PAT_BYTE:
            begin
                if (pat_done)
                    start_pattern();
                fold_byte(1'b0, b);
            end
            afsm_pkg::OP_PAT_END:
            begin
                if (pat_done)
                    start_pattern();
                close_pattern();
            end
            afsm_pkg::OP_TXT_BYTE:
            begin
                if (!pat_done)
                    close_pattern();
                fold_byte(1'b1, b);
            end
            default:
            begin
                if (!pat_done)
                    close_pattern();
                flush_lead(1'b1);
                if (pat_overflow)
                    a.found = 1'b0;
                else if (pat_len == 0)
                    a.found = 1'b1;
                else
                    a.found = hit_seen;
                a.overflow = pat_overflow;
                a.tag      = answers_made;
                answers_made++;
                match_answers.push_back(a);
                text_seen = 0;
                hit_seen  = 1'b0;
                lead_hold = '0;
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_matcher();
            match_answers.delete();
            answers_made = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (match_answers.size() == 0)
                begin
                    report_mismatch("result with no end-of-text request waiting");
                end
                else
                begin
                    head = match_answers.pop_front();
                    if (found !== head.found)
                        report_mismatch($sformatf("result %0d: found %b, predicted %b",
                                                  head.tag, found, head.found));
                    if (pattern_overflow !== head.overflow)
                        report_mismatch($sformatf("result %0d: overflow %b, predicted %b",
                                                  head.tag, pattern_overflow, head.overflow));
                    results_seen++;
                    if (head.found)
                        hits_seen++;
                    if (head.overflow)
                        overflows_seen++;
                end
            end
            if (in_valid && in_ready)
                fold_and_match(afsm_pkg::op_t'(opcode), data_byte);
        end
        answers_due <= match_answers.size();
    end

endmodule

>>> bench/accent_folding_substring_match_tb.sv
// top of the testbench for the accent folding matcher: stimulus, watchdog and verdict
module accent_folding_substring_match_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] byte_q_t [$];

    localparam int unsigned REQUEST_TARGET = 1450;
    localparam int unsigned QUIET_LIMIT    = 4000;

    // continuation bytes after 0xC3 that fold to A, C, E, N, O
    localparam logic [7:0] ACCENT_TAIL [12] = '{
        8'h80, 8'h81, 8'h84, 8'h87, 8'h89, 8'h91,
        8'h96, 8'hA0, 8'hA4, 8'hA9, 8'hB1, 8'hB6
    };

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [1:0] opcode    = afsm_pkg::OP_PAT_BYTE;
    logic [7:0] data_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       found;
    logic       pattern_overflow;

    int unsigned mismatches;
    int unsigned answers_due;
    int unsigned results_seen;
    int unsigned hits_seen;
    int unsigned overflows_seen;
    int unsigned requests_sent = 0;
    int unsigned tx_idle_pct   = 21;
    int unsigned rx_idle_pct   = 85;
    int unsigned quiet_cycles  = 0;
    byte_q_t     pattern_bytes;

    accent_folding_substring_match u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .data_byte        (data_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .found            (found),
        .pattern_overflow (pattern_overflow)
    );

    accent_folding_substring_match_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .data_byte        (data_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .found            (found),
        .pattern_overflow (pattern_overflow),
        .mismatches       (mismatches),
        .answers_due      (answers_due),
        .results_seen     (results_seen),
        .hits_seen        (hits_seen),
        .overflows_seen   (overflows_seen)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("no request or result moved for %0d cycles", quiet_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_request(afsm_pkg::op_t op, logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid  <= 1'b0;
            data_byte <= 8'($urandom_range(255));
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        data_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        requests_sent++;
    endtask

    task automatic send_bytes(afsm_pkg::op_t op, byte_q_t bytes);
        foreach (bytes[i])
            send_request(op, bytes[i]);
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (answers_due != 0)
            @(negedge clk);
    endtask

    // one character: mostly a small alphabet so that matches are frequent
    function automatic byte_q_t random_unit();
        logic [7:0] letters [5] = '{8'h61, 8'h65, 8'h6E, 8'h6F, 8'h63};
        byte_q_t u;
        case ($urandom_range(9))
            0, 1, 2, 3:
                u.push_back(letters[$urandom_range(4)]
                            ^ ($urandom_range(1) ? afsm_pkg::CASE_DELTA : 8'h00));
            4, 5:
            begin
                u.push_back(afsm_pkg::LEAD_C2 | 8'h01);
                u.push_back(ACCENT_TAIL[$urandom_range(11)]);
            end
            6:
            begin
                u.push_back(afsm_pkg::LEAD_C2 | 8'($urandom_range(1)));
                u.push_back(8'($urandom_range(255)));
            end
            7: u.push_back(8'($urandom_range(255)));
            8: u.push_back(8'($urandom_range(127)));
            default:
            begin
                // superscript two, folds to the digit
                u.push_back(afsm_pkg::LEAD_C2);
                u.push_back(8'hB2);
            end
        endcase
        return u;
    endfunction

    function automatic byte_q_t random_chars(int unsigned n);
        byte_q_t q;
        repeat (n)
            q = {q, random_unit()};
        return q;
    endfunction

    // flip the case of ascii letters that are not continuation bytes
    function automatic byte_q_t vary_case(byte_q_t src);
        byte_q_t q;
        q = src;
        foreach (q[i])
            if ((q[i] | afsm_pkg::CASE_DELTA) >= afsm_pkg::ASCII_LC_A &&
                (q[i] | afsm_pkg::CASE_DELTA) <= afsm_pkg::ASCII_LC_Z &&
                (i == 0 || (q[i - 1] & afsm_pkg::LEAD_MASK) != afsm_pkg::LEAD_C2) &&
                $urandom_range(1))
                q[i] = q[i] ^ afsm_pkg::CASE_DELTA;
        return q;
    endfunction

    // new pattern (or keep the old one), then a few texts with or without it
    task automatic run_session();
        byte_q_t     txt;
        int unsigned shape;
        int unsigned units;
        shape = $urandom_range(19);
        if (shape != 2)
        begin
            if (shape == 0)
                units = 0;
            else if (shape == 1)
                units = $urandom_range(30, 36);
            else
                units = $urandom_range(1, 4);
            pattern_bytes = random_chars(units);
            send_bytes(afsm_pkg::OP_PAT_BYTE, pattern_bytes);
            // a text byte closes an open pattern too
            if (units == 0 || $urandom_range(99) < 85)
                send_request(afsm_pkg::OP_PAT_END, 8'($urandom_range(255)));
        end
        repeat ($urandom_range(1, 3))
        begin
            txt = random_chars($urandom_range(0, ($urandom_range(9) == 0) ? 40 : 6));
            if ($urandom_range(1))
                txt = {txt, vary_case(pattern_bytes), random_chars($urandom_range(0, 3))};
            send_bytes(afsm_pkg::OP_TXT_BYTE, txt);
            send_request(afsm_pkg::OP_TXT_END, 8'($urandom_range(255)));
        end
    endtask

    task automatic run_noise();
        repeat ($urandom_range(1, 6))
            send_request(afsm_pkg::op_t'($urandom_range(3)), 8'($urandom_range(255)));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty pattern after reset matches anything
        send_request(afsm_pkg::OP_TXT_END, 8'hFF);
        // accented pattern against accented text, each letter in the opposite case
        send_bytes(afsm_pkg::OP_PAT_BYTE, '{8'h61, 8'hC3, 8'h89});
        send_request(afsm_pkg::OP_PAT_END, 8'h00);
        send_bytes(afsm_pkg::OP_TXT_BYTE, '{8'h41, 8'hC3, 8'hA9});
        send_request(afsm_pkg::OP_TXT_END, 8'h00);
        // lead byte ending the pattern and the text
        send_request(afsm_pkg::OP_PAT_BYTE, 8'hC2);
        send_request(afsm_pkg::OP_PAT_END, 8'h55);
        send_request(afsm_pkg::OP_TXT_BYTE, 8'hC2);
        send_request(afsm_pkg::OP_TXT_END, 8'hAA);
        // byte extremes and a lead byte followed by ascii
        send_bytes(afsm_pkg::OP_PAT_BYTE, '{8'h00, 8'hFF, 8'hC3, 8'h41});
        send_request(afsm_pkg::OP_PAT_END, 8'hFF);
        send_bytes(afsm_pkg::OP_TXT_BYTE, '{8'h00, 8'hFF, 8'h61});
        send_request(afsm_pkg::OP_TXT_END, 8'h00);
        // end of pattern right after a closed one gives an empty pattern
        send_request(afsm_pkg::OP_PAT_END, 8'h00);
        send_request(afsm_pkg::OP_TXT_BYTE, 8'h80);
        send_request(afsm_pkg::OP_TXT_END, 8'h00);
        // text byte while the pattern is still open
        send_request(afsm_pkg::OP_PAT_BYTE, 8'h7A);
        send_request(afsm_pkg::OP_TXT_BYTE, 8'h5A);
        send_request(afsm_pkg::OP_TXT_END, 8'h00);

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 85 : 0;
            rx_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 21 : 0;
            hold_until_drained();
            while (requests_sent < REQUEST_TARGET * (phase + 1) / 3)
            begin
                case ($urandom_range(14))
                    0: run_noise();
                    1:
                    begin
                        run_session();
                        hold_until_drained();
                    end
                    default: run_session();
                endcase
            end
        end

        hold_until_drained();
        repeat (6) @(negedge clk);
        $display("sent %0d requests under three idle mixes; checked %0d end-of-text results",
                 requests_sent, results_seen);
        $display("%0d results reported a match and %0d a pattern overflow",
                 hits_seen, overflows_seen);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> accent_folding_substring_match.f
rtl/afsm_pkg.sv
rtl/afsm_fold.sv
rtl/afsm_match.sv
rtl/accent_folding_substring_match.sv
bench/accent_folding_substring_match_checker.sv
bench/accent_folding_substring_match_tb.sv
